/* rtl/srrw_pkg.sv */
// Package for the selective-repeat receive window.
// Holds the sizes, widths and shared types; it depends on nothing else.
`default_nettype none
package srrw_pkg;
	localparam int WINDOW    = 8;
	localparam int SEQ_BITS  = 16;
	localparam int WL_BITS   = 4;
	localparam int DATA_BITS = 64;
	localparam int SLOT_BITS = (WINDOW > 1) ? $clog2(WINDOW) : 1;

	localparam logic [WL_BITS-1:0] WL_RESET = WL_BITS'(WINDOW);

	localparam logic KIND_ACK     = 1'b0;
	localparam logic KIND_DELIVER = 1'b1;

	typedef logic [SEQ_BITS-1:0]  seq_t;
	typedef logic [SLOT_BITS-1:0] slot_t;
	typedef logic [DATA_BITS-1:0] data_t;

	// Write request into the payload buffer.
	typedef struct packed {
		logic  en;
		slot_t addr;
		data_t data;
	} srrw_wr_t;
endpackage
`default_nettype wire

/* rtl/srrw_if.sv */
// Valid/ready channel interfaces for packets in and results out.
// Depends on srrw_pkg for the field types.
`default_nettype none
interface srrw_pkt_if import srrw_pkg::*; ();
	logic  valid;
	logic  ready;
	seq_t  seq_number;
	logic  checksum_ok;
	data_t payload_word;

	modport source (output valid, seq_number, checksum_ok, payload_word, input ready);
	modport sink   (input valid, seq_number, checksum_ok, payload_word, output ready);
endinterface

interface srrw_res_if import srrw_pkg::*; ();
	logic  valid;
	logic  ready;
	logic  kind;
	seq_t  ack_number;
	data_t delivered_payload;
	logic  last;

	modport source (output valid, kind, ack_number, delivered_payload, last, input ready);
	modport sink   (input valid, kind, ack_number, delivered_payload, last, output ready);
endinterface
`default_nettype wire

/* rtl/srrw_slot_ram.sv */
// Payload buffer of the receive window: one write port, one registered read port.
// Depends on srrw_pkg.
`default_nettype none
module srrw_slot_ram import srrw_pkg::*; (
	input  wire logic     clk,
	input  wire srrw_wr_t wr,
	input  wire slot_t    rd_addr,
	output data_t         rd_data
);
	data_t mem [WINDOW];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		rd_data <= mem[rd_addr];
	end
endmodule
`default_nettype wire

/* rtl/selective_repeat_receive_window_top.sv */
// Top level of the selective-repeat receive window: sequencer, window state,
// output register. Depends on srrw_pkg, srrw_if and srrw_slot_ram.
//
//  channel | direction | payload                                          | handshake
//  pkt     | in        | seq_number, checksum_ok, payload_word            | valid/ready
//  res     | out       | kind, ack_number, delivered_payload, last        | valid/ready
//  cfg     | in        | cfg_wr_data (window_length)                      | cfg_wr_en
//
// A request is classified in steps (accept, forward distance, backward
// distance, decision), then each payload the walk releases passes a read and
// an emit state, as the buffer read is registered and one subtractor serves
// all distance and base arithmetic. pkt.ready is high only while the sequencer
// is idle. A stalled result register holds the sequencer in place; nothing is lost.
// Reset clears the window base, head slot, valid bits and sets window_length to 8.
`default_nettype none
module selective_repeat_receive_window_top import srrw_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	srrw_pkt_if.sink                pkt,
	srrw_res_if.source              res,
	input  wire logic               cfg_wr_en,
	input  wire logic [WL_BITS-1:0] cfg_wr_data
);
	// Sequencer states.
	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_AHEAD  = 3'd1;
	localparam logic [2:0] ST_BEHIND = 3'd2;
	localparam logic [2:0] ST_DECIDE = 3'd3;
	localparam logic [2:0] ST_READ   = 3'd4;
	localparam logic [2:0] ST_EMIT   = 3'd5;

	logic [2:0]         state_q;
	logic [WL_BITS-1:0] wl_q;
	seq_t               base_q;
	slot_t              head_q;
	logic [WINDOW-1:0]  valid_q;
	slot_t              walked_q;

	// Captured request.
	seq_t  seq_q;
	logic  good_q;
	data_t word_q;
	seq_t  ahead_q;
	seq_t  behind_q;

	// Result register.
	logic  out_valid_q;
	logic  kind_q;
	seq_t  ack_q;
	data_t payload_q;
	logic  last_q;

	// The one shared subtractor: forward distance, backward distance, and the
	// base increment (subtracting all ones adds one modulo the sequence space).
	seq_t sub_a;
	seq_t sub_b;
	seq_t sub_y;

	always_comb begin
		case (state_q)
			ST_BEHIND: begin
				sub_a = base_q;
				sub_b = seq_q;
			end
			ST_EMIT: begin
				sub_a = base_q;
				sub_b = '1;
			end
			default: begin
				sub_a = seq_q;
				sub_b = base_q;
			end
		endcase
	end

	assign sub_y = sub_a - sub_b;

	// Effective window span: zero counts as one, oversize is clipped.
	seq_t span;
	always_comb begin
		if (wl_q == '0) begin
			span = SEQ_BITS'(1);
		end else if (32'(wl_q) > WINDOW) begin
			span = SEQ_BITS'(WINDOW);
		end else begin
			span = SEQ_BITS'(wl_q);
		end
	end

	logic in_win;
	logic is_dup;
	assign in_win = good_q && (ahead_q < span);
	assign is_dup = good_q && (behind_q != '0) && (behind_q <= span);

	// Buffer slot of the request: head plus forward distance, wrapped.
	logic [SLOT_BITS:0] slot_sum;
	slot_t              slot_w;
	assign slot_sum = {1'b0, head_q} + {1'b0, ahead_q[SLOT_BITS-1:0]};
	assign slot_w   = (32'(slot_sum) >= WINDOW) ? SLOT_BITS'(32'(slot_sum) - WINDOW)
	                                            : slot_sum[SLOT_BITS-1:0];

	// Next head after a release, wrapped.
	logic [SLOT_BITS:0] head_inc;
	slot_t              head_nx;
	assign head_inc = {1'b0, head_q} + 1'b1;
	assign head_nx  = (32'(head_inc) >= WINDOW) ? '0 : head_inc[SLOT_BITS-1:0];

	logic  out_free;
	assign out_free = !out_valid_q || res.ready;

	// A release ends the walk when the walk has covered the whole buffer or
	// the following slot is empty.
	logic walk_end;
	assign walk_end = (32'(walked_q) == WINDOW - 1) || !valid_q[head_nx];

	srrw_wr_t ram_wr;
	data_t    ram_rd;

	assign ram_wr.en   = (state_q == ST_DECIDE) && in_win && out_free;
	assign ram_wr.addr = slot_w;
	assign ram_wr.data = word_q;

	srrw_slot_ram u_ram (
		.clk     (clk),
		.wr      (ram_wr),
		.rd_addr (head_q),
		.rd_data (ram_rd)
	);

	assign pkt.ready = (state_q == ST_IDLE);

	// Sequencer and window state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			wl_q     <= WL_RESET;
			base_q   <= '0;
			head_q   <= '0;
			valid_q  <= '0;
			walked_q <= '0;
		end else begin
			if (cfg_wr_en) begin
				wl_q <= cfg_wr_data;
			end
			case (state_q)
				ST_IDLE: begin
					if (pkt.valid) begin
						state_q <= ST_AHEAD;
					end
				end
				ST_AHEAD: begin
					state_q <= ST_BEHIND;
				end
				ST_BEHIND: begin
					state_q <= ST_DECIDE;
				end
				ST_DECIDE: begin
					if (!(in_win || is_dup)) begin
						state_q <= ST_IDLE;
					end else if (out_free) begin
						if (in_win) begin
							valid_q[slot_w] <= 1'b1;
						end
						walked_q <= '0;
						state_q  <= (in_win && ahead_q == '0) ? ST_READ : ST_IDLE;
					end
				end
				ST_READ: begin
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (out_free) begin
						valid_q[head_q] <= 1'b0;
						head_q          <= head_nx;
						base_q          <= sub_y;
						walked_q        <= walked_q + 1'b1;
						state_q         <= walk_end ? ST_IDLE : ST_READ;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Request capture and distances; no reset needed.
	always_ff @(posedge clk) begin
		if (pkt.valid && pkt.ready) begin
			seq_q  <= pkt.seq_number;
			good_q <= pkt.checksum_ok;
			word_q <= pkt.payload_word;
		end
		if (state_q == ST_AHEAD) begin
			ahead_q <= sub_y;
		end
		if (state_q == ST_BEHIND) begin
			behind_q <= sub_y;
		end
	end

	// Result register: an acknowledgement from the decision, a payload per walk step.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= ((state_q == ST_DECIDE) && (in_win || is_dup))
			            || (state_q == ST_EMIT);
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (state_q == ST_EMIT) begin
				kind_q    <= KIND_DELIVER;
				ack_q     <= '0;
				payload_q <= ram_rd;
				last_q    <= walk_end;
			end else begin
				kind_q    <= KIND_ACK;
				ack_q     <= seq_q;
				payload_q <= '0;
				last_q    <= !(in_win && ahead_q == '0);
			end
		end
	end

	assign res.valid             = out_valid_q;
	assign res.kind              = kind_q;
	assign res.ack_number        = ack_q;
	assign res.delivered_payload = payload_q;
	assign res.last              = last_q;

	// A release always finds its head slot filled.
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EMIT |-> valid_q[head_q])
		else $error("release walk reached an empty head slot");

	// Between requests the head slot is never left filled.
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> !valid_q[head_q])
		else $error("head slot filled while idle");

	// Every released payload moves the base forward by exactly one.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT && out_free) |=> base_q == $past(base_q) + 1'b1)
		else $error("window base did not advance by one on release");

	// The base moves only during the release walk.
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_EMIT |=> $stable(base_q))
		else $error("window base changed outside the release walk");
endmodule
`default_nettype wire

/* bench/selective_repeat_receive_window_top_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the selective-repeat receive window top level.
// Depends on srrw_pkg, the srrw_if channel interfaces and the RTL top module.

module selective_repeat_receive_window_top_tb;
	import srrw_pkg::*;

	// One result as it leaves the block.
	typedef struct packed {
		logic  kind;
		seq_t  ack_number;
		data_t delivered_payload;
		logic  last;
	} result_t;

	// Rows of the opening table. A typed row carries its results written out.
	// A predicted row gets them from the window model below. A config row
	// writes window_length.
	typedef enum logic [1:0] {ROW_PKT, ROW_TYPED, ROW_CFG} row_kind_t;

	typedef struct packed {
		row_kind_t           kind;
		logic [WL_BITS-1:0]  wl;
		seq_t                seq;
		logic                ok;
		data_t               data;
		logic [1:0]          n_typed;
		result_t             r0;
		result_t             r1;
	} stim_row_t;

	localparam result_t NO_RESULT = '0;
	localparam data_t   PAY_A     = 64'h0123_4567_89AB_CDEF;
	localparam data_t   PAY_B     = 64'hFEDC_BA98_7654_3210;
	localparam data_t   PAY_ONES  = 64'hFFFF_FFFF_FFFF_FFFF;

	// A dropped packet leaves no trace on the result side, so before a register
	// write the block gets this many cycles to finish classifying it.
	localparam int SETTLE_CYCLES = 12;
	// Cycles allowed after the last expected result for strays to show up.
	localparam int TAIL_CYCLES   = 48;
	// Slowest correct run is well under ten million ns; this is several times
	// that figure.
	localparam longint RUN_LIMIT_NS = 64'd50_000_000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en;
	logic [WL_BITS-1:0] cfg_wr_data;

	srrw_pkt_if pkt_ch();
	srrw_res_if res_ch();

	selective_repeat_receive_window_top uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.pkt         (pkt_ch),
		.res         (res_ch),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Window model state, kept in step with the block at every accepted
	// request and every register write.
	logic [WL_BITS-1:0] win_len;
	seq_t               win_base;
	slot_t              head;
	logic               slot_full [WINDOW];
	data_t              slot_word [WINDOW];

	result_t step_results[$];   // results of the request just accepted
	result_t due_results[$];    // results still to come out, oldest first
	stim_row_t opening_rows[$];

	int  fault_count = 0;
	bit  steady_tx = 1'b0;      // sender never pauses while set
	bit  steady_rx = 1'b0;      // receiver never stalls while set

	function automatic result_t ack_res(seq_t n, logic fin);
		result_t r;
		r = '0;
		r.kind = KIND_ACK;
		r.ack_number = n;
		r.last = fin;
		return r;
	endfunction

	function automatic result_t dlv_res(data_t d, logic fin);
		result_t r;
		r = '0;
		r.kind = KIND_DELIVER;
		r.delivered_payload = d;
		r.last = fin;
		return r;
	endfunction

	function automatic stim_row_t row_pkt(seq_t s, logic ok, data_t d);
		stim_row_t r;
		r = '0;
		r.kind = ROW_PKT;
		r.seq = s;
		r.ok = ok;
		r.data = d;
		return r;
	endfunction

	function automatic stim_row_t row_typed(seq_t s, logic ok, data_t d,
			logic [1:0] n, result_t r0, result_t r1);
		stim_row_t r;
		r = row_pkt(s, ok, d);
		r.kind = ROW_TYPED;
		r.n_typed = n;
		r.r0 = r0;
		r.r1 = r1;
		return r;
	endfunction

	function automatic stim_row_t row_cfg(logic [WL_BITS-1:0] v);
		stim_row_t r;
		r = '0;
		r.kind = ROW_CFG;
		r.wl = v;
		return r;
	endfunction

	// Appends one row to the opening table.
	function automatic void add_row(stim_row_t r);
		opening_rows = {opening_rows, r};
	endfunction

	// Slots in use: zero counts as one, anything past the buffer as the buffer.
	function automatic int unsigned span_now();
		if (win_len == 0)
			return 1;
		if (win_len > WINDOW)
			return WINDOW;
		return win_len;
	endfunction

	// Works out the results of one accepted request into step_results and
	// advances the window state the way the block must.
	function automatic void predict_receive(seq_t s, logic ok, data_t d);
		int unsigned span;
		seq_t ahead;
		seq_t behind;
		slot_t slot;
		span = span_now();
		ahead = s - win_base;
		behind = win_base - s;
		step_results.delete();
		if (!ok)
			return;
		if (ahead < span) begin
			slot = slot_t'((int'(head) + int'(ahead)) % WINDOW);
			slot_full[slot] = 1'b1;
			slot_word[slot] = d;
			step_results = {step_results, ack_res(s, 1'b0)};
			// Only the packet at the base starts the release walk. Stale slots
			// left behind by a shrink are released too once the walk gets there.
			if (ahead == 0) begin
				for (int walked = 0; walked < WINDOW; walked++) begin
					if (!slot_full[head])
						break;
					step_results = {step_results, dlv_res(slot_word[head], 1'b0)};
					slot_full[head] = 1'b0;
					head = slot_t'((int'(head) + 1) % WINDOW);
					win_base = win_base + 1'b1;
				end
			end
		end else if (behind >= 1 && behind <= span) begin
			// Previous window: acknowledged again, nothing stored.
			step_results = {step_results, ack_res(s, 1'b0)};
		end
		if (step_results.size() > 0)
			step_results[step_results.size() - 1].last = 1'b1;
	endfunction

	task automatic note_fault(input string what);
		fault_count++;
		if (fault_count <= 10)
			$display("%s", what);
	endtask

	// Mostly short gaps, now and then a long one.
	function automatic int gap_len(bit steady);
		int unsigned pick;
		if (steady)
			return 0;
		pick = $urandom_range(0, 99);
		if (pick < 55)
			return 0;
		if (pick < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Offers one request and returns at the edge that accepts it. Valid is left
	// high, so that a following request goes out back to back.
	task automatic send_row(input stim_row_t row);
		pkt_ch.valid <= 1'b1;
		pkt_ch.seq_number <= row.seq;
		pkt_ch.checksum_ok <= row.ok;
		pkt_ch.payload_word <= row.data;
		do @(posedge clk); while (!pkt_ch.ready);
		predict_receive(row.seq, row.ok, row.data);
		if (row.kind == ROW_TYPED) begin
			if (row.n_typed > 0)
				due_results = {due_results, row.r0};
			if (row.n_typed > 1)
				due_results = {due_results, row.r1};
		end else begin
			foreach (step_results[i])
				due_results = {due_results, step_results[i]};
		end
	endtask

	task automatic hold_sender(input int cycles);
		if (cycles > 0) begin
			pkt_ch.valid <= 1'b0;
			repeat (cycles) @(posedge clk);
		end
	endtask

	// The register is only written with the block idle: nothing offered,
	// every result out, and a short pause for a packet that makes none.
	task automatic write_window_length(input logic [WL_BITS-1:0] v);
		pkt_ch.valid <= 1'b0;
		while (due_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		win_len = v;
	endtask

	// Random request shaped around the current window: mostly good packets
	// inside it in random order, with duplicates, packets past the end, stray
	// numbers and bad checksums mixed in.
	function automatic stim_row_t random_row();
		int unsigned span;
		int unsigned pick;
		seq_t s;
		logic ok;
		data_t d;
		span = span_now();
		pick = $urandom_range(0, 99);
		ok = 1'b1;
		if (pick < 62)
			s = win_base + seq_t'($urandom_range(0, span - 1));
		else if (pick < 72)
			s = win_base - seq_t'($urandom_range(1, span));
		else if (pick < 80)
			s = win_base + seq_t'($urandom_range(span, span + 12));
		else if (pick < 88)
			s = seq_t'($urandom);
		else begin
			s = win_base + seq_t'($urandom_range(0, span));
			ok = 1'b0;
		end
		case ($urandom_range(0, 15))
			0: d = '0;
			1: d = PAY_ONES;
			default: d = {$urandom, $urandom};
		endcase
		return row_pkt(s, ok, d);
	endfunction

	// One phase of random traffic under a fresh window_length, with the
	// idling style picked for the whole phase.
	task automatic run_random_phase(input int items);
		logic [WL_BITS-1:0] v;
		v = WL_BITS'($urandom_range(0, 15));
		if ($urandom_range(0, 1))
			v = WL_BITS'($urandom_range(1, WINDOW));
		write_window_length(v);
		steady_tx = ($urandom_range(0, 3) == 0);
		steady_rx = ($urandom_range(0, 3) == 0);
		repeat (items) begin
			send_row(random_row());
			hold_sender(gap_len(steady_tx));
		end
	endtask

	// Result side: checks every accepted result against the oldest expected
	// one, then decides ready for the next cycle.
	initial begin : result_check
		result_t got;
		result_t want;
		int stall;
		stall = 0;
		res_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (res_ch.valid && res_ch.ready) begin
				got.kind = res_ch.kind;
				got.ack_number = res_ch.ack_number;
				got.delivered_payload = res_ch.delivered_payload;
				got.last = res_ch.last;
				if (due_results.size() == 0) begin
					note_fault($sformatf("unexpected result: kind=%0d ack=%h payload=%h last=%0d",
						got.kind, got.ack_number, got.delivered_payload, got.last));
				end else begin
					want = due_results.pop_front();
					if (got.kind !== want.kind || got.ack_number !== want.ack_number ||
							got.delivered_payload !== want.delivered_payload ||
							got.last !== want.last) begin
						note_fault($sformatf({"result mismatch: expected kind=%0d ack=%h ",
							"payload=%h last=%0d, got kind=%0d ack=%h payload=%h last=%0d"},
							want.kind, want.ack_number, want.delivered_payload, want.last,
							got.kind, got.ack_number, got.delivered_payload, got.last));
					end
				end
			end
			if (steady_rx)
				stall = 0;
			if (stall > 0) begin
				res_ch.ready <= 1'b0;
				stall--;
			end else begin
				res_ch.ready <= 1'b1;
				stall = gap_len(steady_rx);
			end
		end
	end

	initial begin : stimulus
		pkt_ch.valid <= 1'b0;
		pkt_ch.seq_number <= '0;
		pkt_ch.checksum_ok <= 1'b0;
		pkt_ch.payload_word <= '0;
		cfg_wr_en <= 1'b0;
		cfg_wr_data <= '0;

		// Model state after reset: full window, base and head at zero.
		win_len = WL_RESET;
		win_base = '0;
		head = '0;
		foreach (slot_full[i]) begin
			slot_full[i] = 1'b0;
			slot_word[i] = '0;
		end

		// Opening table. Comments give the window base before each row.
		// Base 0, window 8: a bad checksum is dropped.
		add_row(row_typed(16'd0, 1'b0, PAY_ONES, 2'd0, NO_RESULT, NO_RESULT));
		// The packet at the base is acknowledged and released at once.
		add_row(row_typed(16'd0, 1'b1, PAY_A, 2'd2,
			ack_res(16'd0, 1'b0), dlv_res(PAY_A, 1'b1)));
		// Base 1: the same number again is a duplicate, acknowledged only.
		add_row(row_typed(16'd0, 1'b1, PAY_B, 2'd1,
			ack_res(16'd0, 1'b1), NO_RESULT));
		// Two behind the base across the wrap of the sequence numbers.
		add_row(row_typed(16'hFFFF, 1'b1, '0, 2'd1,
			ack_res(16'hFFFF, 1'b1), NO_RESULT));
		// One past the last slot of the window is dropped.
		add_row(row_typed(16'd9, 1'b1, PAY_A, 2'd0, NO_RESULT, NO_RESULT));
		// Fill the far end of the window and overwrite a buffered packet.
		add_row(row_pkt(16'd8, 1'b1, PAY_ONES));
		add_row(row_pkt(16'd3, 1'b1, PAY_A));
		add_row(row_pkt(16'd3, 1'b1, PAY_B));
		add_row(row_pkt(16'd2, 1'b1, '0));
		// The base arrives last and releases three payloads in order.
		add_row(row_pkt(16'd1, 1'b1, PAY_ONES));
		// Base 4: reverse order; the last one releases 4..8 with 8 long buffered.
		add_row(row_pkt(16'd7, 1'b1, PAY_B));
		add_row(row_pkt(16'd6, 1'b1, PAY_A));
		add_row(row_pkt(16'd5, 1'b1, PAY_ONES));
		add_row(row_pkt(16'd4, 1'b1, '0));
		// Base 9, window of one slot.
		add_row(row_cfg(4'd1));
		add_row(row_pkt(16'd10, 1'b1, PAY_A));
		add_row(row_pkt(16'd8, 1'b1, PAY_B));
		add_row(row_pkt(16'd9, 1'b1, PAY_ONES));
		// Base 10, a window length of zero behaves as one slot.
		add_row(row_cfg(4'd0));
		add_row(row_pkt(16'd11, 1'b1, PAY_A));
		add_row(row_pkt(16'd10, 1'b1, PAY_B));
		// Base 11, a length above the buffer behaves as the full buffer. Park
		// a packet five ahead, then shrink to two slots so it goes stale.
		add_row(row_cfg(4'd15));
		add_row(row_pkt(16'd16, 1'b1, PAY_ONES));
		add_row(row_cfg(4'd2));
		add_row(row_pkt(16'd12, 1'b1, PAY_A));
		add_row(row_pkt(16'd11, 1'b1, PAY_B));
		add_row(row_pkt(16'd14, 1'b1, '0));
		add_row(row_pkt(16'd13, 1'b1, PAY_A));
		// Base 15: this release walks on into the stale slot of 16.
		add_row(row_pkt(16'd15, 1'b1, PAY_B));
		add_row(row_cfg(4'd8));

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (opening_rows[i]) begin
			if (opening_rows[i].kind == ROW_CFG) begin
				write_window_length(opening_rows[i].wl);
			end else begin
				send_row(opening_rows[i]);
				hold_sender(gap_len(steady_tx));
			end
		end

		repeat (4) run_random_phase(29);

		// A second round of random traffic under fresh window lengths.
		repeat (4) run_random_phase(29);

		pkt_ch.valid <= 1'b0;
		steady_rx = 1'b0;
		while (due_results.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (due_results.size() != 0)
			note_fault($sformatf("%0d expected results never came out", due_results.size()));

		if (fault_count == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

	// Hard stop in case the block hangs.
	initial begin : watchdog
		#(RUN_LIMIT_NS);
		$display("Regression FAIL");
		$finish;
	end

endmodule
